// File: hdl/gmef_pkg.sv
// ----------------------------------------------------------------------------
// gmef_pkg
// Shared types and constants of the gated median / EMA distance filter.
// ----------------------------------------------------------------------------
`default_nettype none

package gmef_pkg;

  // Ring of recent accepted samples
  localparam int WIN = 5;
  typedef logic [2:0] slot_t;
  localparam slot_t WIN_CNT = 3'(WIN);
  localparam slot_t MED_RANK = 3'(WIN / 2);

  // Fixed-point formats
  localparam int FRAC_W  = 16;
  localparam int ALPHA_W = 17;
  localparam int GATE_W  = 32;
  localparam int REJ_W   = 8;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_GATE_THRESHOLD = 2'd0;
  localparam cfg_idx_t CFG_MAX_REJECT     = 2'd1;
  localparam cfg_idx_t CFG_ALPHA          = 2'd2;

  // Register reset values
  localparam logic [GATE_W-1:0]  GATE_RST  = 32'd65536;
  localparam logic [REJ_W-1:0]   MAXREJ_RST = 8'd3;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd19661;

endpackage

`default_nettype wire

// File: hdl/gated_median_ema_filter.sv
// ----------------------------------------------------------------------------
// gated_median_ema_filter
// Outlier-gated median-of-five exponential distance filter, Q16.16.
// ----------------------------------------------------------------------------
// One sample request is taken every clock while the result side keeps up;
// each request yields exactly one result request, which passes through the
// input register and then the result register. All per-sample work -
// gate compare, ring update, five-entry median and the single alpha
// multiply of the average update - sits between those two registers, and
// that path, which also closes the loop on the filter state, sets the
// clock rate. No clearing pass follows reset. Configuration writes are
// always ready and should be issued only while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module gated_median_ema_filter import gmef_pkg::*; #(
  parameter int DW = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // sample channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [DW-1:0]         in_sample,
  input  wire logic                  in_sample_ok,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [DW-1:0]         out_estimate,
  output logic                       out_has_estimate,
  output logic                       out_gate_exceeded,
  output logic                       out_reinitialised,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int GW = (DW > GATE_W) ? DW : GATE_W;

  // configuration registers
  logic [GATE_W-1:0]  gate_r;
  logic [REJ_W-1:0]   max_rej_r;
  logic [ALPHA_W-1:0] alpha_r;

  // input register
  logic          s1_vld_r;
  logic [DW-1:0] smp_r;
  logic          ok_r;

  // filter state
  logic [WIN-1:0][DW-1:0] window_r, window_nxt;
  slot_t                  slot_r, slot_nxt;
  slot_t                  fill_r, fill_nxt;
  logic [DW-1:0]          avg_r, avg_nxt;
  logic                   avg_ok_r, avg_ok_nxt;
  logic [REJ_W-1:0]       rej_r, rej_nxt;

  // result register
  logic          out_vld_r;
  logic [DW-1:0] est_r;
  logic          has_r, gated_r, reinit_r;

  // handshake control
  logic out_adv, s1_fire;
  logic in_take;

  // datapath
  logic [DW-1:0]    delta;
  logic             over, gated, reinit, skip, take;
  logic [REJ_W-1:0] rej_inc;
  slot_t            slot_wr;
  logic [DW-1:0]    med_win, med_in, ema_out;

  // ---- handshake ----
  assign out_adv   = !out_vld_r || !out_stall;
  assign s1_fire   = s1_vld_r && out_adv;
  assign in_stall  = s1_vld_r && !out_adv;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // ---- gate decision ----
  always_comb begin
    delta   = (smp_r > avg_r) ? (smp_r - avg_r) : (avg_r - smp_r);
    over    = GW'(delta) > GW'(gate_r);
    rej_inc = rej_r + 1'b1;
    gated   = ok_r && avg_ok_r && over;
    reinit  = gated && !(rej_inc < max_rej_r);
    skip    = gated && !reinit;
    take    = ok_r && !skip;
  end

  // ---- ring, fill count and reject counter ----
  always_comb begin
    slot_wr  = (slot_r >= WIN_CNT) ? '0 : slot_r;
    slot_nxt = (slot_wr == WIN_CNT - 3'd1) ? '0 : slot_wr + 3'd1;
    for (int i = 0; i < WIN; i++) begin
      window_nxt[i] = (reinit || slot_wr == 3'(i)) ? smp_r : window_r[i];
    end
    if (reinit) begin
      fill_nxt = WIN_CNT;
    end else if (fill_r < WIN_CNT) begin
      fill_nxt = fill_r + 3'd1;
    end else begin
      fill_nxt = fill_r;
    end
    if (ok_r && avg_ok_r) begin
      rej_nxt = (gated && !reinit) ? rej_inc : '0;
    end else begin
      rej_nxt = rej_r;
    end
  end

  gmef_median5 #(.DW(DW)) u_median (
    .win (window_nxt),
    .med (med_win)
  );

  assign med_in = (fill_nxt < WIN_CNT) ? smp_r : med_win;

  gmef_ema #(.DW(DW)) u_ema (
    .avg     (avg_r),
    .med     (med_in),
    .alpha   (alpha_r),
    .avg_new (ema_out)
  );

  // ---- average update ----
  always_comb begin
    avg_nxt    = avg_r;
    avg_ok_nxt = avg_ok_r;
    if (take) begin
      avg_ok_nxt = 1'b1;
      if (!avg_ok_r) begin
        avg_nxt = med_in;
      end else if (reinit) begin
        avg_nxt = smp_r;
      end else begin
        avg_nxt = ema_out;
      end
    end
  end

  // ---- configuration registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_r    <= GATE_RST;
      max_rej_r <= MAXREJ_RST;
      alpha_r   <= ALPHA_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GATE_THRESHOLD: gate_r <= cfg_data[GATE_W-1:0];
        CFG_MAX_REJECT:     max_rej_r <= cfg_data[REJ_W-1:0];
        CFG_ALPHA: begin
          // weights above one saturate to one
          alpha_r <= (cfg_data[ALPHA_W-1:0] > ALPHA_ONE) ? ALPHA_ONE
                                                         : cfg_data[ALPHA_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // ---- input register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      smp_r <= in_sample;
      ok_r  <= in_sample_ok;
    end
  end

  // ---- filter state ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      slot_r   <= '0;
      fill_r   <= '0;
      avg_r    <= '0;
      avg_ok_r <= 1'b0;
      rej_r    <= '0;
    end else if (s1_fire) begin
      avg_r    <= avg_nxt;
      avg_ok_r <= avg_ok_nxt;
      rej_r    <= rej_nxt;
      if (take) begin
        window_r <= window_nxt;
        slot_r   <= slot_nxt;
        fill_r   <= fill_nxt;
      end
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      est_r    <= avg_nxt;
      has_r    <= avg_ok_nxt;
      gated_r  <= gated;
      reinit_r <= reinit;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_estimate      = est_r;
  assign out_has_estimate  = has_r;
  assign out_gate_exceeded = gated_r;
  assign out_reinitialised = reinit_r;

endmodule

`default_nettype wire

// File: hdl/gmef_median5.sv
// ----------------------------------------------------------------------------
// gmef_median5
// Median of the five ring entries by parallel ranking: each entry counts
// the entries that sort ahead of it (ties broken by position), and the
// entry with the middle rank is selected.
// ----------------------------------------------------------------------------
`default_nettype none

module gmef_median5 import gmef_pkg::*; #(
  parameter int DW = 32
) (
  input  wire logic [WIN-1:0][DW-1:0] win,
  output logic      [DW-1:0]          med
);

  logic [WIN-1:0][2:0] rank;

  // Rank every entry against all others
  always_comb begin
    rank = '0;
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN; j++) begin
        if (j < i) begin
          rank[i] = rank[i] + {2'b00, (win[j] <= win[i])};
        end else if (j > i) begin
          rank[i] = rank[i] + {2'b00, (win[j] < win[i])};
        end
      end
    end
  end

  // Exactly one entry holds the middle rank
  always_comb begin
    med = '0;
    for (int i = 0; i < WIN; i++) begin
      med = med | (win[i] & {DW{rank[i] == MED_RANK}});
    end
  end

endmodule

`default_nettype wire

// File: hdl/gmef_ema.sv
// ----------------------------------------------------------------------------
// gmef_ema
// Exponential average step: avg + round_half_up(alpha * (med - avg) / 2^16).
// Same value as (alpha*med + (1-alpha)*avg + half) >> 16 with one multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module gmef_ema import gmef_pkg::*; #(
  parameter int DW = 32
) (
  input  wire logic [DW-1:0]      avg,
  input  wire logic [DW-1:0]      med,
  input  wire logic [ALPHA_W-1:0] alpha,
  output logic      [DW-1:0]      avg_new
);

  localparam int PW = DW + ALPHA_W + 2;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_W - 1);

  logic signed [PW-1:0] diff_x;
  logic signed [PW-1:0] alpha_x;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] step;
  logic signed [PW-1:0] sum;

  always_comb begin
    // signed difference, sign-extended to product width
    diff_x  = $signed({{(PW-DW){1'b0}}, med}) - $signed({{(PW-DW){1'b0}}, avg});
    alpha_x = $signed({{(PW-ALPHA_W){1'b0}}, alpha});
    prod    = diff_x * alpha_x;
    step    = (prod + HALF) >>> FRAC_W;
    sum     = $signed({{(PW-DW){1'b0}}, avg}) + step;
    avg_new = sum[DW-1:0];
  end

endmodule

`default_nettype wire

// File: tb/sv/gmef_checker.sv
// ----------------------------------------------------------------------------
// gmef_checker
// Watches the sample, result and configuration channels of the gated
// median / EMA filter. It keeps its own copy of the filter state and
// registers, predicts one result per accepted sample request, and compares
// every accepted result request, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module gmef_checker import gmef_pkg::*; #(
  parameter int DW = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire logic [DW-1:0]         in_sample,
  input  wire logic                  in_sample_ok,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire logic [DW-1:0]         out_estimate,
  input  wire logic                  out_has_estimate,
  input  wire logic                  out_gate_exceeded,
  input  wire logic                  out_reinitialised,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending,
  output int                         result_count,
  output int                         gated_count,
  output int                         reinit_count
);

  typedef struct packed {
    logic [DW-1:0] estimate;
    logic          has_estimate;
    logic          gate_exceeded;
    logic          reinitialised;
  } filter_result_t;

  // predicted results, oldest first
  filter_result_t expected_q[$];
  filter_result_t want;

  // register copies
  logic [GATE_W-1:0]  gate_thr;
  logic [REJ_W-1:0]   rej_limit;
  logic [ALPHA_W-1:0] alpha_w;

  // filter state copies
  logic [DW-1:0]    ring [WIN];
  int unsigned      ring_wr;
  int unsigned      ring_fill;
  logic [DW-1:0]    avg;
  logic             avg_ok;
  logic [REJ_W-1:0] rej_cnt;

  // middle value of the five ring slots
  function automatic logic [DW-1:0] ring_median();
    logic [DW-1:0] srt [WIN];
    logic [DW-1:0] key;
    int j;
    for (int i = 0; i < WIN; i++) srt[i] = ring[i];
    for (int i = 1; i < WIN; i++) begin
      key = srt[i];
      j = i;
      while (j > 0 && srt[j-1] > key) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = key;
    end
    return srt[MED_RANK];
  endfunction

  // advance the filter copy by one sample and build the result it gives
  task automatic filter_step(input logic [DW-1:0] s, input logic ok,
                             output filter_result_t r);
    logic [DW-1:0] delta;
    logic [DW-1:0] med;
    logic [63:0]   acc;
    logic          skip;
    r = '0;
    skip = 1'b0;
    if (ok) begin
      // outlier gate, only once an estimate exists
      if (avg_ok) begin
        delta = (s > avg) ? s - avg : avg - s;
        if (64'(delta) > 64'(gate_thr)) begin
          rej_cnt = rej_cnt + 1'b1;
          r.gate_exceeded = 1'b1;
          if (rej_cnt < rej_limit) begin
            skip = 1'b1;
          end else begin
            // too many in a row: jump to the new target
            avg = s;
            rej_cnt = '0;
            r.reinitialised = 1'b1;
            for (int i = 0; i < WIN; i++) ring[i] = s;
            ring_fill = WIN;
          end
        end else begin
          rej_cnt = '0;
        end
      end
      // ring update, median and exponential average
      if (!skip) begin
        if (ring_fill < WIN) ring_fill++;
        ring[ring_wr] = s;
        ring_wr = (ring_wr + 1) % WIN;
        med = (ring_fill < WIN) ? s : ring_median();
        if (!avg_ok) begin
          avg = med;
          avg_ok = 1'b1;
        end else begin
          acc = 64'(alpha_w) * 64'(med) + 64'(ALPHA_ONE - alpha_w) * 64'(avg) + 64'd32768;
          avg = acc[DW-1+FRAC_W:FRAC_W];
        end
      end
    end
    r.estimate = avg;
    r.has_estimate = avg_ok;
  endtask

  task automatic check_field(input string field, input logic [63:0] want_v, got_v);
    if (got_v !== want_v) begin
      fail_count++;
      if (fail_count <= 30)
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      gate_thr = GATE_RST;
      rej_limit = MAXREJ_RST;
      alpha_w = ALPHA_RST;
      for (int i = 0; i < WIN; i++) ring[i] = '0;
      ring_wr = 0;
      ring_fill = 0;
      avg = '0;
      avg_ok = 1'b0;
      rej_cnt = '0;
      expected_q.delete();
    end else begin
      // result request: compare with the oldest prediction
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 30)
            $display("%0t: result with nothing expected, estimate %h", $time, out_estimate);
        end else begin
          want = expected_q.pop_front();
          result_count++;
          if (want.gate_exceeded) gated_count++;
          if (want.reinitialised) reinit_count++;
          check_field("estimate", 64'(want.estimate), 64'(out_estimate));
          check_field("has_estimate", 64'(want.has_estimate), 64'(out_has_estimate));
          check_field("gate_exceeded", 64'(want.gate_exceeded), 64'(out_gate_exceeded));
          check_field("reinitialised", 64'(want.reinitialised), 64'(out_reinitialised));
        end
      end
      // sample request: predict its result
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        filter_step(in_sample, in_sample_ok, want);
        expected_q.push_back(want);
      end
      // register write
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        case (cfg_index)
          CFG_GATE_THRESHOLD: gate_thr = cfg_data[GATE_W-1:0];
          CFG_MAX_REJECT:     rej_limit = cfg_data[REJ_W-1:0];
          CFG_ALPHA: begin
            alpha_w = (cfg_data[ALPHA_W-1:0] > ALPHA_ONE) ? ALPHA_ONE : cfg_data[ALPHA_W-1:0];
          end
          default: ;
        endcase
      end
    end
    pending = expected_q.size();
  end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the gated median / EMA filter. A directed run
// covers the gate, re-initialisation and register corner cases; random
// phases then feed noisy tracks with spikes and target jumps under varying
// register settings and random idling on both channels.
// ----------------------------------------------------------------------------
module tb import gmef_pkg::*; ();

  localparam int DW = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 150;
  localparam int SAMPLE_GOAL = 1820;
  localparam logic [DW-1:0] DIST_MAX = '1;
  // index with no register behind it
  localparam cfg_idx_t CFG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_stall, in_sample_ok;
  logic [DW-1:0] in_sample;
  logic out_valid, out_stall;
  logic [DW-1:0] out_estimate;
  logic out_has_estimate, out_gate_exceeded, out_reinitialised;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count, pending, result_count, gated_count, reinit_count;
  int cycle_count;
  int items_sent;
  int phases;
  int snd_max = 17;
  int rcv_max = 3;
  bit long_hold_req;
  logic [GATE_W-1:0] cur_gate = GATE_RST;
  logic [REJ_W-1:0] cur_rej = MAXREJ_RST;
  logic [DW-1:0] target;

  gated_median_ema_filter #(.DW(DW)) dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_sample, .in_sample_ok,
    .out_valid, .out_stall, .out_estimate, .out_has_estimate,
    .out_gate_exceeded, .out_reinitialised,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  gmef_checker #(.DW(DW)) u_checker (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_sample, .in_sample_ok,
    .out_valid, .out_stall, .out_estimate, .out_has_estimate,
    .out_gate_exceeded, .out_reinitialised,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending, .result_count, .gated_count, .reinit_count
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
    $display("== FAIL ==");
    $finish;
  end

  // result side: random stall before each request, one long hold on demand
  initial begin : result_sink
    int hold;
    forever begin
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        hold = $urandom_range(0, rcv_max);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (out_valid !== 1'b1);
      @(posedge clk);
    end
  end

  function automatic int idle_span();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 3;
      default: return 17;
    endcase
  endfunction

  // distance within +/- span of base, clipped to the sample range
  function automatic logic [DW-1:0] jitter(input logic [DW-1:0] base, input longint span);
    logic [63:0] draw;
    longint v;
    draw = {$urandom, $urandom};
    v = longint'(base) + longint'(draw % (2 * span + 1)) - span;
    if (v < 0) v = 0;
    if (v > longint'(DIST_MAX)) v = longint'(DIST_MAX);
    return v[DW-1:0];
  endfunction

  // a point just beyond the current gate on either side of base
  function automatic logic [DW-1:0] far_from(input logic [DW-1:0] base);
    longint step, up, down;
    step = longint'(cur_gate) + 1 + longint'($urandom_range(0, 1 << 20));
    up = longint'(base) + step;
    down = longint'(base) - step;
    if (up <= longint'(DIST_MAX) && (down < 0 || $urandom_range(0, 1) == 1))
      return up[DW-1:0];
    if (down >= 0) return down[DW-1:0];
    return $urandom;
  endfunction

  // one sample request, after a random gap
  task automatic push_sample(input logic [DW-1:0] s, input logic ok);
    int gap;
    gap = $urandom_range(0, snd_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_sample_ok <= ok;
    do @(negedge clk); while (in_stall !== 1'b0);
    @(posedge clk);
    items_sent++;
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (cfg_ready !== 1'b1);
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] gate, rej, alph);
    write_reg(CFG_GATE_THRESHOLD, gate);
    write_reg(CFG_MAX_REJECT, rej);
    write_reg(CFG_ALPHA, alph);
    cfg_valid <= 1'b0;
    cur_gate = gate;
    cur_rej = rej[REJ_W-1:0];
    phases++;
  endtask

  task automatic write_random_config();
    logic [CFG_DATA_W-1:0] g, r, a;
    case ($urandom_range(0, 9))
      0: g = '0;
      1: g = '1;
      2: g = $urandom;
      default: g = $urandom_range(32'h100, 32'h40_0000);
    endcase
    case ($urandom_range(0, 7))
      0: r = '0;
      1: r = 32'd255;
      default: r = $urandom_range(1, 6);
    endcase
    case ($urandom_range(0, 7))
      0: a = '0;
      1: a = ALPHA_ONE;
      2: a = $urandom_range(32'h1_0001, 32'h1_FFFF);
      default: a = $urandom_range(1, 65535);
    endcase
    // junk above the register width is dropped by the block
    if ($urandom_range(0, 3) == 0) r[CFG_DATA_W-1:REJ_W] = $urandom;
    if ($urandom_range(0, 3) == 0) a[CFG_DATA_W-1:ALPHA_W] = $urandom;
    configure(g, r, a);
  endtask

  // noisy track around a target with spikes, target jumps and invalid samples
  task automatic random_phase(input int n_items, input bit reconfig, input bit pressure);
    int sent;
    int pick;
    int run;
    logic [DW-1:0] far;
    longint spread;
    if (reconfig) begin
      drain_results();
      write_random_config();
    end
    snd_max = idle_span();
    rcv_max = idle_span();
    if (pressure) begin
      // result side holds off while samples keep coming back to back
      snd_max = 0;
      long_hold_req = 1'b1;
    end
    sent = 0;
    while (sent < n_items) begin
      spread = longint'(cur_gate >> $urandom_range(1, 3));
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        push_sample($urandom, 1'b0);
        sent++;
      end else if (pick < 12) begin
        push_sample($urandom, 1'b1);
        sent++;
      end else if (pick < 15) begin
        // target jump: samples stay far until the block re-initialises
        target = far_from(target);
        push_sample(jitter(target, spread), 1'b1);
        sent++;
      end else if (pick < 19) begin
        // short spike away from the target, then back
        far = far_from(target);
        run = $urandom_range(1, (cur_rej < 7) ? cur_rej + 1 : 8);
        repeat (run) begin
          push_sample(jitter(far, spread >> 3), 1'b1);
          sent++;
        end
      end else if (pick == 19) begin
        drain_results();
      end else begin
        push_sample(jitter(target, spread), 1'b1);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    int phase_no;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sample <= '0;
    in_sample_ok <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_GATE_THRESHOLD;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: invalid before any estimate, seed, fill, gate, re-init
    push_sample(32'hFFFF_FFFF, 1'b0);
    push_sample(32'h0010_0000, 1'b1);
    push_sample(32'h0010_8000, 1'b1);
    push_sample(32'h000F_C000, 1'b1);
    push_sample(32'h0010_4000, 1'b1);
    push_sample(32'h0010_0000, 1'b1);
    push_sample(32'h0015_0000, 1'b1);
    push_sample(32'h0015_0000, 1'b0);
    push_sample(32'h0015_0000, 1'b1);
    push_sample(32'h0015_0000, 1'b1);

    // zero gate, zero max reject, alpha written above one
    drain_results();
    write_reg(CFG_UNUSED, $urandom);
    configure(32'h0, 32'hFFFF_FF00, 32'h0001_FFFF);
    push_sample(32'h0015_0000, 1'b1);
    push_sample(32'h0000_0000, 1'b1);
    push_sample(32'hFFFF_FFFF, 1'b1);

    // widest gate, largest max reject, alpha of zero holds the estimate
    drain_results();
    configure(32'hFFFF_FFFF, 32'd255, 32'd0);
    push_sample(32'h0000_0000, 1'b1);
    push_sample(32'hFFFF_FFFF, 1'b1);
    push_sample(32'h1234_5678, 1'b1);
    push_sample(32'h0000_0000, 1'b0);

    // two rejects pending, then max reject lowered below the count
    drain_results();
    configure(32'h100, 32'd5, 32'h8000);
    push_sample(32'hFFFF_FF80, 1'b1);
    push_sample(32'h0000_0000, 1'b1);
    push_sample(32'h0000_0000, 1'b1);
    drain_results();
    write_reg(CFG_MAX_REJECT, 32'd1);
    cfg_valid <= 1'b0;
    cur_rej = 8'd1;
    push_sample(32'h0000_0000, 1'b1);
    push_sample(32'h0000_0080, 1'b1);

    // random phases
    target = $urandom;
    phase_no = 0;
    while (items_sent < SAMPLE_GOAL) begin
      random_phase($urandom_range(60, 200), phase_no % 4 != 3, phase_no == 2);
      phase_no++;
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("%0d samples sent, %0d results checked under %0d register settings",
             items_sent, result_count, phases);
    $display("%0d gated samples, %0d re-initialisations, %0d cycles",
             gated_count, reinit_count, cycle_count);
    if (fail_count == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
